@@ rtl/tlc_pkg.sv @@
package tlc_pkg;

  // Default geometry of the target store
  localparam int STORE_BYTES_DEF = 65536;
  localparam int TILE_W_DEF      = 4;
  localparam int TILE_H_DEF      = 4;

  // Field widths
  localparam int CHAN_CFG_W = 11;
  localparam int DIM_CFG_W  = 9;
  localparam int CHAN_W     = 10;
  localparam int ROW_W      = 8;
  localparam int COL_W      = 8;
  localparam int DATA_W     = 8;
  localparam int LADDR_W    = 16;
  localparam int CNT_W      = 27;

  localparam int MAX_CHANNELS = 1024;
  localparam int MAX_ROWS     = 256;
  localparam int MAX_COLS     = 256;

  // Internal widths, sized for tiles up to 16x16 and stores up to 16 MiB
  localparam int SADDR_W     = 24;
  localparam int PAD_W       = 9;   // padded dimension, at most 271
  localparam int STRIDE_W    = 13;  // tile-row stride, at most 4336
  localparam int PLANE_W     = 17;  // padded plane size, at most 73441
  localparam int OFF_W       = 28;  // full tiled offset
  localparam int SUB_W       = 4;   // position inside a tile
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = 17;
  localparam int SETTLE_W    = 2;

  localparam int QUEUE_DEPTH = 4;

  // Register port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_CHANNELS = 2'd0;
  localparam logic [1:0] REG_ROWS     = 2'd1;
  localparam logic [1:0] REG_COLS     = 2'd2;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_COMPARE = 1'b1;

  typedef struct packed {
    logic [CHAN_CFG_W-1:0] chans;
    logic [DIM_CFG_W-1:0]  rows;
    logic [DIM_CFG_W-1:0]  cols;
  } tlc_cfg_t;

  // One classified operation between front and back
  typedef struct packed {
    logic               is_load;
    logic [SADDR_W-1:0] addr;
    logic [DATA_W-1:0]  data;
    logic               oor;
    logic [CHAN_W-1:0]  chan;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic               last;
  } tlc_op_t;

  typedef struct packed {
    logic              mismatch;
    logic [CHAN_W-1:0] chan;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [DATA_W-1:0] golden;
    logic [DATA_W-1:0] target;
    logic [CNT_W-1:0]  diff;
    logic              oor;
    logic              last;
  } tlc_res_t;

endpackage

@@ rtl/tlc_ram.sv @@
module tlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end else begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/tlc_queue.sv @@
module tlc_queue #(
  parameter int DEPTH = tlc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  tlc_pkg::tlc_op_t din,
  output logic             full,
  input  logic             rd,
  output tlc_pkg::tlc_op_t dout,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);

  tlc_pkg::tlc_op_t mem_r [DEPTH];
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [PTR_W:0]   count_r, count_nxt;

  assign full  = (count_r == (PTR_W+1)'(DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[head_r];

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (wr) begin
      tail_nxt = (tail_r == PTR_W'(DEPTH-1)) ? '0 : tail_r + 1'b1;
    end
    if (rd) begin
      head_nxt = (head_r == PTR_W'(DEPTH-1)) ? '0 : head_r + 1'b1;
    end
    if (wr && !rd) begin
      count_nxt = count_r + 1'b1;
    end else if (rd && !wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[tail_r] <= din;
    end
  end

endmodule

@@ rtl/tlc_front.sv @@
module tlc_front #(
  parameter int STORE_BYTES = tlc_pkg::STORE_BYTES_DEF,
  parameter int TILE_WIDTH  = tlc_pkg::TILE_W_DEF,
  parameter int TILE_HEIGHT = tlc_pkg::TILE_H_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tlc_pkg::tlc_cfg_t            cfg,
  input  logic                         cfg_wr,
  input  logic                         push,
  output logic                         full,
  input  logic                         kind,
  input  logic [tlc_pkg::LADDR_W-1:0]  load_addr,
  input  logic [tlc_pkg::DATA_W-1:0]   data_byte,
  output logic                         q_push,
  output tlc_pkg::tlc_op_t             q_data,
  input  logic                         q_full
);

  localparam int PAD_W    = tlc_pkg::PAD_W;
  localparam int RECIP_W  = tlc_pkg::RECIP_W;
  localparam int PROD_W   = PAD_W + RECIP_W;
  localparam int STRIDE_W = tlc_pkg::STRIDE_W;
  localparam int PLANE_W  = tlc_pkg::PLANE_W;
  localparam int OFF_W    = tlc_pkg::OFF_W;
  localparam int SUB_W    = tlc_pkg::SUB_W;
  localparam int CHAN_W   = tlc_pkg::CHAN_W;
  localparam int ROW_W    = tlc_pkg::ROW_W;
  localparam int COL_W    = tlc_pkg::COL_W;
  localparam int CCFG_W   = tlc_pkg::CHAN_CFG_W;
  localparam int DCFG_W   = tlc_pkg::DIM_CFG_W;
  localparam int SETTLE_W = tlc_pkg::SETTLE_W;

  localparam int RECIP_C   = (2**tlc_pkg::RECIP_SHIFT + TILE_WIDTH - 1) / TILE_WIDTH;
  localparam int RECIP_R   = (2**tlc_pkg::RECIP_SHIFT + TILE_HEIGHT - 1) / TILE_HEIGHT;
  localparam int TILE_AREA = TILE_WIDTH * TILE_HEIGHT;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  // ---- clamped dimensions
  logic [CCFG_W-1:0] chans_cl;
  logic [DCFG_W-1:0] rows_cl, cols_cl;

  always_comb begin
    if (cfg.chans == '0) begin
      chans_cl = CCFG_W'(1);
    end else if (cfg.chans > CCFG_W'(tlc_pkg::MAX_CHANNELS)) begin
      chans_cl = CCFG_W'(tlc_pkg::MAX_CHANNELS);
    end else begin
      chans_cl = cfg.chans;
    end
    if (cfg.rows == '0) begin
      rows_cl = DCFG_W'(1);
    end else if (cfg.rows > DCFG_W'(tlc_pkg::MAX_ROWS)) begin
      rows_cl = DCFG_W'(tlc_pkg::MAX_ROWS);
    end else begin
      rows_cl = cfg.rows;
    end
    if (cfg.cols == '0) begin
      cols_cl = DCFG_W'(1);
    end else if (cfg.cols > DCFG_W'(tlc_pkg::MAX_COLS)) begin
      cols_cl = DCFG_W'(tlc_pkg::MAX_COLS);
    end else begin
      cols_cl = cfg.cols;
    end
  end

  // ---- geometry: three registered steps after each register write
  logic [PAD_W-1:0]    cols_up, rows_up;
  logic [PROD_W-1:0]   qc_prod, qr_prod;
  logic [PAD_W-1:0]    qc_r, qr_r;
  logic [PAD_W+4:0]    pcols_full, prows_full;
  logic [PAD_W-1:0]    pcols_r, prows_r;
  logic [STRIDE_W-1:0] stride_nxt, stride_r;
  logic [PLANE_W-1:0]  plane_nxt, plane_r;
  logic [SETTLE_W-1:0] settle_r, settle_nxt;

  assign cols_up    = PAD_W'(cols_cl) + PAD_W'(TILE_WIDTH - 1);
  assign rows_up    = PAD_W'(rows_cl) + PAD_W'(TILE_HEIGHT - 1);
  assign qc_prod    = PROD_W'(cols_up) * PROD_W'(RECIP_C);
  assign qr_prod    = PROD_W'(rows_up) * PROD_W'(RECIP_R);
  assign pcols_full = (PAD_W+5)'(qc_r) * (PAD_W+5)'(TILE_WIDTH);
  assign prows_full = (PAD_W+5)'(qr_r) * (PAD_W+5)'(TILE_HEIGHT);
  assign stride_nxt = STRIDE_W'(qc_r) * STRIDE_W'(TILE_AREA);
  assign plane_nxt  = PLANE_W'(pcols_r) * PLANE_W'(prows_r);

  always_comb begin
    if (cfg_wr) begin
      settle_nxt = '1;
    end else if (settle_r != '0) begin
      settle_nxt = settle_r - 1'b1;
    end else begin
      settle_nxt = settle_r;
    end
  end

  always_ff @(posedge clk) begin
    qc_r     <= qc_prod[tlc_pkg::RECIP_SHIFT +: PAD_W];
    qr_r     <= qr_prod[tlc_pkg::RECIP_SHIFT +: PAD_W];
    pcols_r  <= pcols_full[PAD_W-1:0];
    prows_r  <= prows_full[PAD_W-1:0];
    stride_r <= stride_nxt;
    plane_r  <= plane_nxt;
  end

  // ---- coordinate counters
  logic [1:0]        state_r, state_nxt;
  logic              accept;
  logic              col_end, row_end, chan_end, last_now;
  logic [CHAN_W-1:0] ch_r, ch_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt, rgrp_r, rgrp_nxt;
  logic [COL_W-1:0]  col_r, col_nxt, cgrp_r, cgrp_nxt;
  logic [SUB_W-1:0]  rsub_r, rsub_nxt, csub_r, csub_nxt;
  logic              load_ok;

  assign full     = (state_r != ST_IDLE) || (settle_r != '0);
  assign accept   = push && !full;
  assign col_end  = (DCFG_W'(col_r) + DCFG_W'(1)) >= cols_cl;
  assign row_end  = (DCFG_W'(row_r) + DCFG_W'(1)) >= rows_cl;
  assign chan_end = (CCFG_W'(ch_r) + CCFG_W'(1)) >= chans_cl;
  assign last_now = col_end && row_end && chan_end;
  assign load_ok  = 32'(load_addr) < 32'(STORE_BYTES);

  always_comb begin
    ch_nxt   = ch_r;
    row_nxt  = row_r;
    rgrp_nxt = rgrp_r;
    rsub_nxt = rsub_r;
    col_nxt  = col_r;
    cgrp_nxt = cgrp_r;
    csub_nxt = csub_r;
    if (accept && kind == tlc_pkg::KIND_COMPARE) begin
      if (last_now) begin
        ch_nxt   = '0;
        row_nxt  = '0;
        rgrp_nxt = '0;
        rsub_nxt = '0;
        col_nxt  = '0;
        cgrp_nxt = '0;
        csub_nxt = '0;
      end else if (!col_end) begin
        col_nxt = col_r + 1'b1;
        if (csub_r == SUB_W'(TILE_WIDTH - 1)) begin
          csub_nxt = '0;
          cgrp_nxt = cgrp_r + 1'b1;
        end else begin
          csub_nxt = csub_r + 1'b1;
        end
      end else begin
        col_nxt  = '0;
        cgrp_nxt = '0;
        csub_nxt = '0;
        if (!row_end) begin
          row_nxt = row_r + 1'b1;
          if (rsub_r == SUB_W'(TILE_HEIGHT - 1)) begin
            rsub_nxt = '0;
            rgrp_nxt = rgrp_r + 1'b1;
          end else begin
            rsub_nxt = rsub_r + 1'b1;
          end
        end else begin
          row_nxt  = '0;
          rgrp_nxt = '0;
          rsub_nxt = '0;
          ch_nxt   = ch_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (kind == tlc_pkg::KIND_COMPARE) begin
            state_nxt = ST_MUL;
          end else if (load_ok) begin
            state_nxt = ST_PUSH;
          end
        end
      end
      ST_MUL:  state_nxt = ST_PUSH;
      ST_PUSH: begin
        if (!q_full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      settle_r <= '1;
      ch_r     <= '0;
      row_r    <= '0;
      rgrp_r   <= '0;
      rsub_r   <= '0;
      col_r    <= '0;
      cgrp_r   <= '0;
      csub_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      settle_r <= settle_nxt;
      ch_r     <= ch_nxt;
      row_r    <= row_nxt;
      rgrp_r   <= rgrp_nxt;
      rsub_r   <= rsub_nxt;
      col_r    <= col_nxt;
      cgrp_r   <= cgrp_nxt;
      csub_r   <= csub_nxt;
    end
  end

  // ---- item capture and offset arithmetic
  logic                        op_load_r;
  logic [tlc_pkg::LADDR_W-1:0] op_addr_r;
  logic [tlc_pkg::DATA_W-1:0]  op_data_r;
  logic [CHAN_W-1:0]           op_ch_r;
  logic [ROW_W-1:0]            op_row_r, op_rgrp_r;
  logic [COL_W-1:0]            op_col_r, op_cgrp_r;
  logic [SUB_W-1:0]            op_rsub_r, op_csub_r;
  logic                        op_last_r;
  logic [OFF_W-1:0]            p_ch_r, p_row_r, p_part_r;
  logic [OFF_W-1:0]            offset;
  logic                        oor;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_load_r <= (kind == tlc_pkg::KIND_LOAD);
      op_addr_r <= load_addr;
      op_data_r <= data_byte;
      op_ch_r   <= ch_r;
      op_row_r  <= row_r;
      op_rgrp_r <= rgrp_r;
      op_rsub_r <= rsub_r;
      op_col_r  <= col_r;
      op_cgrp_r <= cgrp_r;
      op_csub_r <= csub_r;
      op_last_r <= last_now;
    end
    if (state_r == ST_MUL) begin
      p_ch_r   <= OFF_W'(op_ch_r) * OFF_W'(plane_r);
      p_row_r  <= OFF_W'(op_rgrp_r) * OFF_W'(stride_r);
      p_part_r <= OFF_W'(op_cgrp_r) * OFF_W'(TILE_AREA)
                + OFF_W'(op_rsub_r) * OFF_W'(TILE_WIDTH)
                + OFF_W'(op_csub_r);
    end
  end

  assign offset = p_ch_r + p_row_r + p_part_r;
  assign oor    = offset >= OFF_W'(STORE_BYTES);

  always_comb begin
    q_data.is_load = op_load_r;
    q_data.addr    = op_load_r ? tlc_pkg::SADDR_W'(op_addr_r)
                               : offset[tlc_pkg::SADDR_W-1:0];
    q_data.data    = op_data_r;
    q_data.oor     = !op_load_r && oor;
    q_data.chan    = op_ch_r;
    q_data.row     = op_row_r;
    q_data.col     = op_col_r;
    q_data.last    = op_last_r;
  end

  assign q_push = (state_r == ST_PUSH) && !q_full;

endmodule

@@ rtl/tlc_back.sv @@
module tlc_back #(
  parameter int STORE_BYTES = tlc_pkg::STORE_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tlc_pkg::tlc_op_t q_data,
  input  logic             q_empty,
  output logic             q_pop,
  output tlc_pkg::tlc_res_t res,
  output logic             res_empty,
  input  logic             res_pop
);

  localparam int AW     = $clog2(STORE_BYTES);
  localparam int DATA_W = tlc_pkg::DATA_W;
  localparam int CNT_W  = tlc_pkg::CNT_W;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [DATA_W-1:0] ram_rdata;

  tlc_pkg::tlc_op_t  s1_r;
  logic              s1_valid_r, s1_valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  tlc_pkg::tlc_res_t out_r;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [CNT_W-1:0]  total_inc;
  logic [DATA_W-1:0] tval;
  logic              miss;

  // Loads drain at once; a compare waits until the read stage and result slot are free.
  assign q_pop = !q_empty &&
                 (q_data.is_load || (!s1_valid_r && (!out_valid_r || res_pop)));

  assign ram_we   = q_pop && q_data.is_load;
  assign ram_addr = q_data.addr[AW-1:0];

  tlc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (q_data.data),
    .rdata (ram_rdata)
  );

  assign tval      = s1_r.oor ? '0 : ram_rdata;
  assign miss      = tval != s1_r.data;
  assign total_inc = total_r + CNT_W'(miss);

  always_comb begin
    s1_valid_nxt  = q_pop && !q_data.is_load;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    if (res_pop) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_valid_r) begin
      out_valid_nxt = 1'b1;
      total_nxt     = s1_r.last ? '0 : total_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_r <= q_data;
    end
    if (s1_valid_r) begin
      out_r.mismatch <= miss;
      out_r.chan     <= s1_r.chan;
      out_r.row      <= s1_r.row;
      out_r.col      <= s1_r.col;
      out_r.golden   <= s1_r.data;
      out_r.target   <= tval;
      out_r.diff     <= total_inc;
      out_r.oor      <= s1_r.oor;
      out_r.last     <= s1_r.last;
    end
  end

  assign res       = out_r;
  assign res_empty = !out_valid_r;

endmodule

@@ rtl/tiled_layout_compare.sv @@
// Channel  | Handshake                          | Beat
// ---------+------------------------------------+--------------------------------------------
// input    | push / full                        | in_kind, in_load_addr, in_data_byte
// result   | pop / empty                        | out_* record, one per compare beat
// config   | psel penable pwrite paddr / pready | num_channels @0, num_rows @4, num_cols @8
//
// Loads pass the front through capture and queue; compares through capture, multiply, and
// add and queue, the offset multiply followed by the offset sum. The back side takes a new
// compare only once the registered store read of the last is done, so the front paces the
// block. After reset and after every register write, full stays high while the padded
// geometry settles. No clearing pass: the store holds garbage until loaded. A full queue
// stalls the front; an unread result the back, and the front once the 4-deep queue fills.
module tiled_layout_compare #(
  parameter int STORE_BYTES = tlc_pkg::STORE_BYTES_DEF,
  parameter int TILE_WIDTH  = tlc_pkg::TILE_W_DEF,
  parameter int TILE_HEIGHT = tlc_pkg::TILE_H_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlc_pkg::PADDR_W-1:0]   paddr,
  input  logic [tlc_pkg::PDATA_W-1:0]   pwdata,
  output logic [tlc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // input beats
  input  logic                          push,
  output logic                          full,
  input  logic                          in_kind,
  input  logic [tlc_pkg::LADDR_W-1:0]   in_load_addr,
  input  logic [tlc_pkg::DATA_W-1:0]    in_data_byte,
  // result beats
  input  logic                          pop,
  output logic                          empty,
  output logic                          out_mismatch,
  output logic [tlc_pkg::CHAN_W-1:0]    out_chan_index,
  output logic [tlc_pkg::ROW_W-1:0]     out_row_index,
  output logic [tlc_pkg::COL_W-1:0]     out_col_index,
  output logic [tlc_pkg::DATA_W-1:0]    out_ref_byte,
  output logic [tlc_pkg::DATA_W-1:0]    out_stored_byte,
  output logic [tlc_pkg::CNT_W-1:0]     out_diff_count,
  output logic                          out_out_of_range,
  output logic                          out_last
);

  // ---- registers: raw values kept for readback, clamping happens in the front
  tlc_pkg::tlc_cfg_t cfg_r, cfg_nxt;
  logic              cfg_we;
  logic [1:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        tlc_pkg::REG_CHANNELS: cfg_nxt.chans = pwdata[tlc_pkg::CHAN_CFG_W-1:0];
        tlc_pkg::REG_ROWS:     cfg_nxt.rows  = pwdata[tlc_pkg::DIM_CFG_W-1:0];
        tlc_pkg::REG_COLS:     cfg_nxt.cols  = pwdata[tlc_pkg::DIM_CFG_W-1:0];
        default:               cfg_nxt       = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chans <= tlc_pkg::CHAN_CFG_W'(1);
      cfg_r.rows  <= tlc_pkg::DIM_CFG_W'(1);
      cfg_r.cols  <= tlc_pkg::DIM_CFG_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (cfg_idx)
      tlc_pkg::REG_CHANNELS: prdata = tlc_pkg::PDATA_W'(cfg_r.chans);
      tlc_pkg::REG_ROWS:     prdata = tlc_pkg::PDATA_W'(cfg_r.rows);
      tlc_pkg::REG_COLS:     prdata = tlc_pkg::PDATA_W'(cfg_r.cols);
      default:               prdata = '0;
    endcase
  end

  // ---- front: coordinates, tiled offset, classification
  logic              q_push, q_full, q_pop, q_empty;
  tlc_pkg::tlc_op_t  q_in, q_out;
  tlc_pkg::tlc_res_t res;

  tlc_front #(
    .STORE_BYTES (STORE_BYTES),
    .TILE_WIDTH  (TILE_WIDTH),
    .TILE_HEIGHT (TILE_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cfg_wr    (cfg_we),
    .push      (push),
    .full      (full),
    .kind      (in_kind),
    .load_addr (in_load_addr),
    .data_byte (in_data_byte),
    .q_push    (q_push),
    .q_data    (q_in),
    .q_full    (q_full)
  );

  tlc_queue #(
    .DEPTH (tlc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_push),
    .din   (q_in),
    .full  (q_full),
    .rd    (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  // ---- back: store access, compare, running count, result slot
  tlc_back #(
    .STORE_BYTES (STORE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_out),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .res       (res),
    .res_empty (empty),
    .res_pop   (pop)
  );

  assign out_mismatch     = res.mismatch;
  assign out_chan_index   = res.chan;
  assign out_row_index    = res.row;
  assign out_col_index    = res.col;
  assign out_ref_byte     = res.golden;
  assign out_stored_byte  = res.target;
  assign out_diff_count   = res.diff;
  assign out_out_of_range = res.oor;
  assign out_last         = res.last;

  // ---- checks
  // geometry must settle before the next beat is taken
  a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> full)
    else $error("input taken right after a register write");

  a_queue_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("front pushed into a full queue");

  a_miss_flag: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_mismatch == (out_ref_byte != out_stored_byte)))
    else $error("mismatch flag disagrees with compared bytes");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_out_of_range) |-> (out_stored_byte == '0))
    else $error("out-of-range target not forced to zero");

endmodule

@@ test/tb_tiled_layout_compare.sv @@
module tb_tiled_layout_compare;
  import tlc_pkg::*;

  localparam longint unsigned STORE      = STORE_BYTES_DEF;
  localparam int              CYCLE_CAP  = 1000000;
  localparam int              HOLD_LEN   = 300;
  localparam int              BEAT_GOAL  = 820;
  localparam int              SETTLE_LEN = 10;

  // Tiled store, geometry and coordinate counters as the block should
  // keep them. Compare beats push the record they must produce.
  class layout_scoreboard;
    logic [DATA_W-1:0]     tgt_mem [STORE_BYTES_DEF];
    bit                    loaded  [STORE_BYTES_DEF];
    logic [CHAN_CFG_W-1:0] chans_reg;
    logic [DIM_CFG_W-1:0]  rows_reg;
    logic [DIM_CFG_W-1:0]  cols_reg;
    logic [CHAN_W-1:0]     ch;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      col;
    logic [CNT_W-1:0]      miss_total;
    tlc_res_t              records_due[$];
    int errors, beats_in, records, miss_seen, oor_seen, ends_seen;

    function new();
      chans_reg = 1;
      rows_reg  = 1;
      cols_reg  = 1;
      ch = 0;
      row = 0;
      col = 0;
      miss_total = 0;
    endfunction

    function longint unsigned eff_dim(longint unsigned v, longint unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function longint unsigned next_offset();
      longint unsigned pc, pr;
      pc = ((eff_dim(cols_reg, MAX_COLS) + TILE_W_DEF - 1) / TILE_W_DEF) * TILE_W_DEF;
      pr = ((eff_dim(rows_reg, MAX_ROWS) + TILE_H_DEF - 1) / TILE_H_DEF) * TILE_H_DEF;
      return longint'(ch) * (pc * pr)
           + (longint'(row) / TILE_H_DEF) * (TILE_H_DEF * pc)
           + (longint'(col) / TILE_W_DEF) * (TILE_W_DEF * TILE_H_DEF)
           + (longint'(row) % TILE_H_DEF) * TILE_W_DEF
           + longint'(col) % TILE_W_DEF;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_CHANNELS: chans_reg = value[CHAN_CFG_W-1:0];
        REG_ROWS:     rows_reg  = value[DIM_CFG_W-1:0];
        REG_COLS:     cols_reg  = value[DIM_CFG_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic kind, logic [LADDR_W-1:0] addr, logic [DATA_W-1:0] d);
      tlc_res_t        r;
      longint unsigned off;
      bit              col_end, row_end, chan_end;
      beats_in++;
      if (kind == KIND_LOAD) begin
        tgt_mem[addr] = d;
        loaded[addr]  = 1'b1;
        return;
      end
      off      = next_offset();
      r.oor    = off >= STORE;
      r.target = r.oor ? '0 : tgt_mem[off[15:0]];
      r.golden = d;
      r.mismatch = r.target != d;
      if (r.mismatch) miss_total = miss_total + 1'b1;
      r.diff = miss_total;
      r.chan = ch;
      r.row  = row;
      r.col  = col;
      // a counter past a shrunken limit wraps as if it sat on the limit
      col_end  = longint'(col) + 1 >= eff_dim(cols_reg, MAX_COLS);
      row_end  = longint'(row) + 1 >= eff_dim(rows_reg, MAX_ROWS);
      chan_end = longint'(ch) + 1 >= eff_dim(chans_reg, MAX_CHANNELS);
      r.last   = col_end && row_end && chan_end;
      if (r.last) begin
        ch = 0;
        row = 0;
        col = 0;
        miss_total = 0;
      end else if (!col_end) begin
        col = col + 1'b1;
      end else begin
        col = 0;
        if (!row_end) begin
          row = row + 1'b1;
        end else begin
          row = 0;
          ch = ch + 1'b1;
        end
      end
      records_due.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task cmp_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("record %0d %s got 0x%0h want 0x%0h", records, name, got,
                                  want));
    endtask

    task check_result(tlc_res_t got);
      tlc_res_t want;
      records++;
      if (records_due.size() == 0) begin
        report_mismatch("result beat with no compare beat waiting");
        return;
      end
      want = records_due.pop_front();
      cmp_field("mismatch", 32'(got.mismatch), 32'(want.mismatch));
      cmp_field("chan_index", 32'(got.chan), 32'(want.chan));
      cmp_field("row_index", 32'(got.row), 32'(want.row));
      cmp_field("col_index", 32'(got.col), 32'(want.col));
      cmp_field("ref_byte", 32'(got.golden), 32'(want.golden));
      cmp_field("stored_byte", 32'(got.target), 32'(want.target));
      cmp_field("diff_count", 32'(got.diff), 32'(want.diff));
      cmp_field("out_of_range", 32'(got.oor), 32'(want.oor));
      cmp_field("last", 32'(got.last), 32'(want.last));
      miss_seen += int'(want.mismatch);
      oor_seen  += int'(want.oor);
      ends_seen += int'(want.last);
    endtask

    task final_check();
      if (records_due.size() != 0)
        report_mismatch($sformatf("%0d records never arrived", records_due.size()));
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                psel, penable, pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                push, full;
  logic                in_kind;
  logic [LADDR_W-1:0]  in_load_addr;
  logic [DATA_W-1:0]   in_data_byte;
  logic                pop, empty;
  logic                out_mismatch;
  logic [CHAN_W-1:0]   out_chan_index;
  logic [ROW_W-1:0]    out_row_index;
  logic [COL_W-1:0]    out_col_index;
  logic [DATA_W-1:0]   out_ref_byte;
  logic [DATA_W-1:0]   out_stored_byte;
  logic [CNT_W-1:0]    out_diff_count;
  logic                out_out_of_range;
  logic                out_last;

  layout_scoreboard sb;
  bit no_idle;     // both sides run flat out while set
  bit hold_req;    // sender asks the result side for a long hold-off
  int beats_sent;
  int cycles;

  tiled_layout_compare i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .push             (push),
    .full             (full),
    .in_kind          (in_kind),
    .in_load_addr     (in_load_addr),
    .in_data_byte     (in_data_byte),
    .pop              (pop),
    .empty            (empty),
    .out_mismatch     (out_mismatch),
    .out_chan_index   (out_chan_index),
    .out_row_index    (out_row_index),
    .out_col_index    (out_col_index),
    .out_ref_byte     (out_ref_byte),
    .out_stored_byte  (out_stored_byte),
    .out_diff_count   (out_diff_count),
    .out_out_of_range (out_out_of_range),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: far above the slowest legal run (every beat waiting out the
  // longest gap on both sides plus the front's pace for a compare).
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_CAP) begin
        $display("timeout after %0d cycles", cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One input beat. push stays high across back-to-back beats; it only
  // drops when a gap is taken.
  task automatic send_beat(input logic kind, input logic [LADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push         <= 1'b1;
    in_kind      <= kind;
    in_load_addr <= addr;
    in_data_byte <= d;
    do @(posedge clk); while (full);
    sb.note_input(kind, addr, d);
    beats_sent++;
  endtask

  // Compare beat at the current coordinate. An in-range cell never loaded
  // is loaded first, so no compare ever reads an unwritten entry.
  task automatic compare_beat(input bit want_match, input logic [DATA_W-1:0] d);
    longint unsigned  off;
    logic [DATA_W-1:0] val;
    off = sb.next_offset();
    if (off < STORE && !sb.loaded[off[15:0]])
      send_beat(KIND_LOAD, off[15:0], 8'($urandom));
    val = d;
    if (want_match) val = (off < STORE) ? sb.tgt_mem[off[15:0]] : '0;
    send_beat(KIND_COMPARE, 16'($urandom), val);
  endtask

  // Sender pauses until every record is back, then lets loads still in the
  // front drain before touching the geometry.
  task automatic wait_drained();
    push <= 1'b0;
    while (sb.records_due.size() != 0) @(posedge clk);
    repeat (SETTLE_LEN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
  endtask

  // Junk above each field checks that only the low bits are kept.
  task automatic set_geometry(input int c, input int r, input int k);
    logic [31:0] junk;
    wait_drained();
    junk = $urandom;
    write_reg(REG_CHANNELS, (junk & ~32'h7FF) | (32'(c) & 32'h7FF));
    junk = $urandom;
    write_reg(REG_ROWS, (junk & ~32'h1FF) | (32'(r) & 32'h1FF));
    junk = $urandom;
    write_reg(REG_COLS, (junk & ~32'h1FF) | (32'(k) & 32'h1FF));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result side: pops at random, with a long hold-off on request.
  initial begin : result_sink
    int       idle_left;
    logic     nxt;
    tlc_res_t got;
    idle_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        got.mismatch = out_mismatch;
        got.chan     = out_chan_index;
        got.row      = out_row_index;
        got.col      = out_col_index;
        got.golden   = out_ref_byte;
        got.target   = out_stored_byte;
        got.diff     = out_diff_count;
        got.oor      = out_out_of_range;
        got.last     = out_last;
        sb.check_result(got);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        idle_left = HOLD_LEN;
      end
      if (idle_left > 0) begin
        nxt = 1'b0;
        idle_left--;
      end else if (!no_idle && $urandom_range(0, 99) < 30) begin
        nxt = 1'b0;
        idle_left = pick_gap();
      end else begin
        nxt = 1'b1;
      end
      pop <= nxt;
    end
  end

  initial begin : stimulus
    int roll, c, r, k, len;
    longint unsigned map_size;
    sb = new();
    no_idle    = 1'b0;
    hold_req   = 1'b0;
    beats_sent = 0;
    rst_n        <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    push         <= 1'b0;
    in_kind      <= KIND_LOAD;
    in_load_addr <= '0;
    in_data_byte <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset geometry 1x1x1, every record is the last of its map.
    send_beat(KIND_LOAD, 16'h0000, 8'h00);
    compare_beat(1'b0, 8'h00);                 // match
    compare_beat(1'b0, 8'hFF);                 // mismatch, count 1
    send_beat(KIND_LOAD, 16'hFFFF, 8'hFF);     // top of store
    send_beat(KIND_LOAD, 16'h0000, 8'hFF);
    compare_beat(1'b0, 8'hFF);                 // match on all-ones
    // Zero dimensions act as one.
    set_geometry(0, 0, 0);
    compare_beat(1'b0, 8'h5A);
    // Step into channel 1, then widen the plane so channel 1 starts past
    // the store: out-of-range beats read as zero.
    set_geometry(2, 1, 1);
    compare_beat(1'b1, 8'h00);
    set_geometry(2, 256, 256);
    compare_beat(1'b0, 8'h00);                 // out of range, matches zero
    compare_beat(1'b0, 8'hA5);                 // out of range, mismatch
    // Values above the limits clamp to them.
    set_geometry(2047, 511, 511);
    compare_beat(1'b0, 8'h3C);
    // Shrink mid-map: counters past the new limits close the map.
    set_geometry(1, 1, 1);
    compare_beat(1'b1, 8'h00);
    set_geometry(1024, 256, 256);
    compare_beat(1'b1, 8'h00);
    compare_beat(1'b0, 8'hC3);
    set_geometry(1, 1, 1);
    compare_beat(1'b0, 8'h81);

    // Back-pressure: result side stalls for a long stretch while a whole
    // 2x4x4 map is offered flat out, so the queue fills and full rises.
    set_geometry(2, 4, 4);
    no_idle  = 1'b1;
    hold_req = 1'b1;
    repeat (32) compare_beat($urandom_range(0, 1), 8'($urandom));
    no_idle = 1'b0;
    wait_drained();

    // Random phases: mostly whole small maps, some cut short, some with
    // degenerate or clamped geometry, noise loads sprinkled in.
    while (beats_sent < BEAT_GOAL) begin
      roll = $urandom_range(0, 99);
      c = $urandom_range(1, 3);
      r = $urandom_range(1, 9);
      k = $urandom_range(1, 9);
      if (roll < 15) begin
        c = 1;
        r = $urandom_range(10, 40);
        k = $urandom_range(10, 40);
      end else if (roll < 25) begin
        case ($urandom_range(0, 2))
          0:       c = $urandom_range(0, 1) ? 0 : 2047;
          1:       r = $urandom_range(0, 1) ? 0 : 511;
          default: k = $urandom_range(0, 1) ? 0 : 511;
        endcase
      end
      set_geometry(c, r, k);
      map_size = sb.eff_dim(c, MAX_CHANNELS) * sb.eff_dim(r, MAX_ROWS)
               * sb.eff_dim(k, MAX_COLS);
      len = (map_size < 60) ? int'(map_size) * $urandom_range(1, 2) : $urandom_range(20, 80);
      if ($urandom_range(0, 99) < 20) len = $urandom_range(1, len);
      no_idle = ($urandom_range(0, 99) < 15);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 99) < 10)
          send_beat(KIND_LOAD, 16'($urandom), 8'($urandom));
        else
          compare_beat($urandom_range(0, 99) < 75, 8'($urandom));
      end
      no_idle = 1'b0;
    end

    wait_drained();
    sb.final_check();
    $display("%0d beats in, %0d records out over random geometries and mid-map changes",
             sb.beats_in, sb.records);
    $display("records: %0d mismatching, %0d out of range, %0d map ends; %0d errors",
             sb.miss_seen, sb.oor_seen, sb.ends_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ tiled_layout_compare.f @@
rtl/tlc_pkg.sv
rtl/tlc_ram.sv
rtl/tlc_queue.sv
rtl/tlc_front.sv
rtl/tlc_back.sv
rtl/tiled_layout_compare.sv
test/tb_tiled_layout_compare.sv
